@@ rtl/rme_pkg.sv @@
// Package: sequencer states, opcodes and condition codes for the execute unit.
package rme_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_D,
    ST_EXEC,
    ST_DIV,
    ST_LOAD,
    ST_STORE,
    ST_FIN
  } rme_state_t;

  localparam logic [7:0] OP_HALT     = 8'h00;
  localparam logic [7:0] OP_ADD      = 8'h01;
  localparam logic [7:0] OP_SUB      = 8'h02;
  localparam logic [7:0] OP_MUL      = 8'h03;
  localparam logic [7:0] OP_DIV      = 8'h04;
  localparam logic [7:0] OP_LD       = 8'h05;
  localparam logic [7:0] OP_ST       = 8'h06;
  localparam logic [7:0] OP_MOV      = 8'h07;
  localparam logic [7:0] OP_ADDI     = 8'h09;
  localparam logic [7:0] OP_SUBI     = 8'h0A;
  localparam logic [7:0] OP_MULI     = 8'h0B;
  localparam logic [7:0] OP_DIVI     = 8'h0C;
  localparam logic [7:0] OP_LDI      = 8'h0D;
  localparam logic [7:0] OP_STI      = 8'h0E;
  localparam logic [7:0] OP_MOVI     = 8'h0F;
  localparam logic [7:0] OP_BR_FIRST = 8'h10;
  localparam logic [7:0] OP_BR_LAST  = 8'h1E;

  localparam logic [3:0] CC_EQ = 4'd0;
  localparam logic [3:0] CC_NE = 4'd1;
  localparam logic [3:0] CC_CS = 4'd2;
  localparam logic [3:0] CC_CC = 4'd3;
  localparam logic [3:0] CC_MI = 4'd4;
  localparam logic [3:0] CC_PL = 4'd5;
  localparam logic [3:0] CC_VS = 4'd6;
  localparam logic [3:0] CC_VC = 4'd7;
  localparam logic [3:0] CC_HI = 4'd8;
  localparam logic [3:0] CC_LS = 4'd9;
  localparam logic [3:0] CC_GE = 4'd10;
  localparam logic [3:0] CC_LT = 4'd11;
  localparam logic [3:0] CC_GT = 4'd12;
  localparam logic [3:0] CC_LE = 4'd13;

  // flags packed as {z, n, c, v}
  function automatic logic cond_holds(input logic [3:0] cc, input logic [3:0] fl);
    logic z, n, c, v;
    z = fl[3];
    n = fl[2];
    c = fl[1];
    v = fl[0];
    case (cc)
      CC_EQ:   cond_holds = z;
      CC_NE:   cond_holds = !z;
      CC_CS:   cond_holds = c;
      CC_CC:   cond_holds = !c;
      CC_MI:   cond_holds = n;
      CC_PL:   cond_holds = !n;
      CC_VS:   cond_holds = v;
      CC_VC:   cond_holds = !v;
      CC_HI:   cond_holds = c && !z;
      CC_LS:   cond_holds = !c || z;
      CC_GE:   cond_holds = (n == v);
      CC_LT:   cond_holds = (n != v);
      CC_GT:   cond_holds = !z && (n == v);
      CC_LE:   cond_holds = z || (n != v);
      default: cond_holds = 1'b1;
    endcase
  endfunction

endpackage

@@ rtl/rme_ifs.sv @@
// Channel interfaces: instruction beats in, execution result beats out.
interface rme_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] dest_field;
  logic [7:0] src_a_field;
  logic [7:0] src_b_field;

  modport source (output valid, opcode, dest_field, src_a_field, src_b_field, input ready);
  modport sink (input valid, opcode, dest_field, src_a_field, src_b_field, output ready);
endinterface

interface rme_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_pc;
  logic               halted;
  logic               flag_z;
  logic               flag_n;
  logic               flag_c;
  logic               flag_v;
  logic               reg_written;
  logic [7:0]         reg_index;
  logic signed [31:0] reg_value;
  logic               mem_written;
  logic [11:0]        mem_address;
  logic [31:0]        mem_value;

  modport source (output valid, next_pc, halted, flag_z, flag_n, flag_c, flag_v, reg_written,
                  reg_index, reg_value, mem_written, mem_address, mem_value, input ready);
  modport sink (input valid, next_pc, halted, flag_z, flag_n, flag_c, flag_v, reg_written,
                reg_index, reg_value, mem_written, mem_address, mem_value, output ready);
endinterface

@@ rtl/register_machine_execute.sv @@
// Register machine execute unit: sequencer, ALU, register file, data memory, divider.
// Sequence: each instruction reads A, B and D, executes, then divides (one quotient bit per
// cycle in the divider), loads or stores if needed, and finishes; a halted machine skips to finish.
// Throughput: one instruction at a time; the next beat is taken while a result waits.
// Reset: synchronous active-low; the data memory is cleared one byte per cycle after reset,
// with in_ch.ready low meanwhile.
module register_machine_execute #(
  parameter int REG_COUNT  = 256,
  parameter int DATA_BYTES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  rme_in_if.sink     in_ch,
  rme_out_if.source  out_ch
);
  localparam int AW = $clog2(DATA_BYTES);

  rme_pkg::rme_state_t state_r, state_nxt;

  logic [7:0]  op_r, d_r, sa_r, sb_r;
  logic [31:0] a_r, b_r;
  logic [31:0] pc_r;
  logic [3:0]  flags_r;
  logic        halt_r;
  logic        wr_r, mw_r;
  logic [31:0] wval_r, mval_r, sh_r;
  logic [11:0] maddr_r;
  logic [AW-1:0] base_r;
  logic [2:0]  cnt_r;

  logic        out_valid_r;
  logic [31:0] o_pc_r, o_rval_r, o_mval_r;
  logic [3:0]  o_flags_r;
  logic        o_halt_r, o_wr_r, o_mw_r;
  logic [7:0]  o_ridx_r;
  logic [11:0] o_maddr_r;

  logic [7:0]  rf_rd_idx;
  logic [31:0] rf_rdata;
  logic        rf_we;
  logic        dm_we, dm_busy;
  logic [7:0]  dm_rdata;
  logic [AW-1:0] dm_addr;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        accept, fin_go, d_ok;

  logic [31:0] bop, sum, dif, prod, ex_addr, ex_pc, ex_wval, br_off;
  logic [3:0]  ex_flags;
  logic        ex_wr, ex_mw, ex_div, ex_ld, ex_halt, addr_ok;

  assign accept = in_ch.valid && in_ch.ready;
  assign fin_go = !out_valid_r || out_ch.ready;
  assign d_ok   = {1'b0, d_r} < 9'(REG_COUNT);

  rme_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk(clk), .rst_n(rst_n), .rd_idx(rf_rd_idx), .rd_data(rf_rdata),
    .we(rf_we), .wr_idx(d_r), .wr_data(wval_r)
  );

  rme_dmem #(.DATA_BYTES(DATA_BYTES)) u_dm (
    .clk(clk), .rst_n(rst_n), .we(dm_we), .addr(dm_addr), .wdata(sh_r[7:0]),
    .rdata(dm_rdata), .busy(dm_busy)
  );

  rme_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_r), .divisor(bop),
    .done(div_done), .quotient(div_q)
  );

  // execute stage
  always_comb begin
    bop      = op_r[3] ? {24'd0, sb_r} : b_r;
    sum      = a_r + bop;
    dif      = a_r - bop;
    prod     = a_r * bop;
    br_off   = {{22{sb_r[7]}}, sb_r, 2'b00};
    ex_addr  = '0;
    ex_pc    = pc_r + 32'd4;
    ex_flags = flags_r;
    ex_wval  = '0;
    ex_wr    = 1'b0;
    ex_mw    = 1'b0;
    ex_div   = 1'b0;
    ex_ld    = 1'b0;
    ex_halt  = 1'b0;
    case (op_r)
      rme_pkg::OP_LD:  ex_addr = a_r;
      rme_pkg::OP_LDI: ex_addr = {24'd0, sb_r};
      rme_pkg::OP_ST:  ex_addr = rf_rdata;
      rme_pkg::OP_STI: ex_addr = {24'd0, d_r};
      default:         ex_addr = '0;
    endcase
    addr_ok = ex_addr <= 32'(DATA_BYTES - 4);
    case (op_r)
      rme_pkg::OP_HALT: begin
        ex_halt = 1'b1;
        ex_pc   = pc_r;
      end
      rme_pkg::OP_ADD, rme_pkg::OP_ADDI: begin
        ex_wval  = sum;
        ex_wr    = 1'b1;
        ex_flags = {sum == 32'd0, sum[31], (sum < a_r) || (sum < bop),
                    ((a_r[31] ^ sum[31]) & (bop[31] ^ sum[31]))};
      end
      rme_pkg::OP_SUB, rme_pkg::OP_SUBI: begin
        ex_wval  = dif;
        ex_wr    = 1'b1;
        ex_flags = {dif == 32'd0, dif[31], $signed(a_r) > $signed(bop),
                    ((a_r[31] ^ bop[31]) & (a_r[31] ^ dif[31]))};
      end
      rme_pkg::OP_MUL, rme_pkg::OP_MULI: begin
        ex_wval = prod;
        ex_wr   = 1'b1;
      end
      rme_pkg::OP_DIV, rme_pkg::OP_DIVI: begin
        ex_div = bop != 32'd0;
      end
      rme_pkg::OP_LD, rme_pkg::OP_LDI: begin
        ex_wr = 1'b1;
        ex_ld = addr_ok;
      end
      rme_pkg::OP_ST, rme_pkg::OP_STI: begin
        ex_mw = addr_ok;
      end
      rme_pkg::OP_MOV: begin
        ex_wval = a_r;
        ex_wr   = 1'b1;
      end
      rme_pkg::OP_MOVI: begin
        ex_wval = {24'd0, sb_r};
        ex_wr   = 1'b1;
      end
      default: begin
        if (op_r inside {[rme_pkg::OP_BR_FIRST:rme_pkg::OP_BR_LAST]} &&
            rme_pkg::cond_holds(op_r[3:0], flags_r)) begin
          ex_pc = pc_r + br_off;
        end
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rme_pkg::ST_CLEAR: if (!dm_busy) state_nxt = rme_pkg::ST_IDLE;
      rme_pkg::ST_IDLE: begin
        if (accept) state_nxt = halt_r ? rme_pkg::ST_FIN : rme_pkg::ST_RD_A;
      end
      rme_pkg::ST_RD_A: state_nxt = rme_pkg::ST_RD_B;
      rme_pkg::ST_RD_B: state_nxt = rme_pkg::ST_RD_D;
      rme_pkg::ST_RD_D: state_nxt = rme_pkg::ST_EXEC;
      rme_pkg::ST_EXEC: begin
        if (ex_div)     state_nxt = rme_pkg::ST_DIV;
        else if (ex_ld) state_nxt = rme_pkg::ST_LOAD;
        else if (ex_mw) state_nxt = rme_pkg::ST_STORE;
        else            state_nxt = rme_pkg::ST_FIN;
      end
      rme_pkg::ST_DIV:   if (div_done) state_nxt = rme_pkg::ST_FIN;
      rme_pkg::ST_LOAD:  if (cnt_r == 3'd4) state_nxt = rme_pkg::ST_FIN;
      rme_pkg::ST_STORE: if (cnt_r == 3'd3) state_nxt = rme_pkg::ST_FIN;
      rme_pkg::ST_FIN:   if (fin_go) state_nxt = rme_pkg::ST_IDLE;
      default:           state_nxt = rme_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = (state_r == rme_pkg::ST_IDLE);
    rf_rd_idx   = d_r;
    case (state_r)
      rme_pkg::ST_RD_A: rf_rd_idx = sa_r;
      rme_pkg::ST_RD_B: rf_rd_idx = sb_r;
      default:          rf_rd_idx = d_r;
    endcase
    rf_we     = (state_r == rme_pkg::ST_FIN) && fin_go && wr_r;
    dm_we     = (state_r == rme_pkg::ST_STORE);
    dm_addr   = base_r + AW'(cnt_r[1:0]);
    div_start = (state_r == rme_pkg::ST_EXEC) && ex_div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rme_pkg::ST_CLEAR;
      pc_r    <= '0;
      flags_r <= '0;
      halt_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rme_pkg::ST_EXEC) begin
        pc_r    <= ex_pc;
        flags_r <= ex_flags;
        halt_r  <= halt_r | ex_halt;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      rme_pkg::ST_IDLE: begin
        op_r   <= in_ch.opcode;
        d_r    <= in_ch.dest_field;
        sa_r   <= in_ch.src_a_field;
        sb_r   <= in_ch.src_b_field;
        wr_r   <= 1'b0;
        mw_r   <= 1'b0;
        wval_r <= '0;
      end
      rme_pkg::ST_RD_B: a_r <= rf_rdata;
      rme_pkg::ST_RD_D: b_r <= rf_rdata;
      rme_pkg::ST_EXEC: begin
        wr_r    <= ex_wr && d_ok;
        wval_r  <= ex_wval;
        mw_r    <= ex_mw;
        maddr_r <= ex_addr[11:0];
        mval_r  <= a_r;
        sh_r    <= a_r;
        base_r  <= ex_addr[AW-1:0];
        cnt_r   <= '0;
      end
      rme_pkg::ST_DIV: begin
        if (div_done) begin
          wr_r   <= d_ok;
          wval_r <= div_q;
        end
      end
      rme_pkg::ST_LOAD: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r != 3'd0) wval_r <= {dm_rdata, wval_r[31:8]};
      end
      rme_pkg::ST_STORE: begin
        cnt_r <= cnt_r + 1'b1;
        sh_r  <= {8'd0, sh_r[31:8]};
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == rme_pkg::ST_FIN && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == rme_pkg::ST_FIN && fin_go) begin
      o_pc_r    <= pc_r;
      o_halt_r  <= halt_r;
      o_flags_r <= flags_r;
      o_wr_r    <= wr_r;
      o_ridx_r  <= wr_r ? d_r : 8'd0;
      o_rval_r  <= wr_r ? wval_r : 32'd0;
      o_mw_r    <= mw_r;
      o_maddr_r <= mw_r ? maddr_r : 12'd0;
      o_mval_r  <= mw_r ? mval_r : 32'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_pc     = o_pc_r;
  assign out_ch.halted      = o_halt_r;
  assign out_ch.flag_z      = o_flags_r[3];
  assign out_ch.flag_n      = o_flags_r[2];
  assign out_ch.flag_c      = o_flags_r[1];
  assign out_ch.flag_v      = o_flags_r[0];
  assign out_ch.reg_written = o_wr_r;
  assign out_ch.reg_index   = o_ridx_r;
  assign out_ch.reg_value   = o_rval_r;
  assign out_ch.mem_written = o_mw_r;
  assign out_ch.mem_address = o_maddr_r;
  assign out_ch.mem_value   = o_mval_r;
endmodule

@@ rtl/rme_regfile.sv @@
// Register file: one read port with registered data, one write port, per-entry valid bits.
module rme_regfile #(
  parameter int REG_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  rd_idx,
  output logic [31:0] rd_data,
  input  logic        we,
  input  logic [7:0]  wr_idx,
  input  logic [31:0] wr_data
);
  localparam int RIW = $clog2(REG_COUNT);

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [31:0]          q_r;
  logic                 sel_r;
  logic                 rd_ok;

  assign rd_ok   = {1'b0, rd_idx} < 9'(REG_COUNT);
  assign rd_data = sel_r ? q_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wr_idx[RIW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx[RIW-1:0]] <= wr_data;
    end
    q_r   <= mem[rd_idx[RIW-1:0]];
    sel_r <= rd_ok && valid_r[rd_idx[RIW-1:0]];
  end
endmodule

@@ rtl/rme_dmem.sv @@
// Byte-wide data memory with a clearing pass after reset.
module rme_dmem #(
  parameter int DATA_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [$clog2(DATA_BYTES)-1:0] addr,
  input  logic [7:0]                    wdata,
  output logic [7:0]                    rdata,
  output logic                          busy
);
  localparam int AW = $clog2(DATA_BYTES);

  logic [7:0]  mem [DATA_BYTES];
  logic [AW:0] clr_cnt_r;
  logic        clr_done;

  assign clr_done = (clr_cnt_r == (AW+1)'(DATA_BYTES));
  assign busy     = !clr_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_cnt_r[AW-1:0]] <= 8'd0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/rme_div.sv @@
// Signed 32-bit divider, one quotient bit per cycle, truncating.
module rme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] quo_r;
  logic [31:0] mb_r;
  logic        neg_r;
  logic [32:0] trial;
  logic        fits;

  assign trial    = {rem_r, quo_r[31]};
  assign fits     = trial >= {1'b0, mb_r};
  assign done     = done_r;
  assign quotient = neg_r ? (32'd0 - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend[31] ? (32'd0 - dividend) : dividend;
      mb_r  <= divisor[31] ? (32'd0 - divisor) : divisor;
      neg_r <= dividend[31] ^ divisor[31];
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? 32'(trial - {1'b0, mb_r}) : trial[31:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end
endmodule

@@ tb/sv/tb_register_machine_execute.sv @@
// Testbench for the register machine execute unit: random programs checked against a predictor.
module tb_register_machine_execute;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        halted;
    logic        fz;
    logic        fn;
    logic        fc;
    logic        fv;
    logic        reg_written;
    logic [7:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [11:0] mem_address;
    logic [31:0] mem_value;
  } exec_result_t;

  class exec_scoreboard;
    logic [31:0]    regs [256];
    logic [7:0]     dmem [4096];
    logic [31:0]    pc;
    logic           z, n, c, v, halt;
    exec_result_t   pending [$];
    int             mismatches;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      {z, n, c, v, halt} = '0;
      mismatches = 0;
    endfunction

    function logic [31:0] word_at(logic [31:0] addr);
      if (addr > 32'd4092) return '0;
      return {dmem[addr + 3], dmem[addr + 2], dmem[addr + 1], dmem[addr]};
    endfunction

    function logic cond_ok(logic [3:0] cc);
      case (cc)
        rme_pkg::CC_EQ: return z;
        rme_pkg::CC_NE: return !z;
        rme_pkg::CC_CS: return c;
        rme_pkg::CC_CC: return !c;
        rme_pkg::CC_MI: return n;
        rme_pkg::CC_PL: return !n;
        rme_pkg::CC_VS: return v;
        rme_pkg::CC_VC: return !v;
        rme_pkg::CC_HI: return c && !z;
        rme_pkg::CC_LS: return !c || z;
        rme_pkg::CC_GE: return n == v;
        rme_pkg::CC_LT: return n != v;
        rme_pkg::CC_GT: return !z && (n == v);
        rme_pkg::CC_LE: return z || (n != v);
        default: return 1'b1;
      endcase
    endfunction

    function void note_instruction(logic [7:0] op, logic [7:0] d, logic [7:0] sa,
                                   logic [7:0] sb);
      exec_result_t r;
      logic [31:0] a, b, w, addr, ma, mb, q;
      logic wr, adv;
      r = '0;
      wr = 0;
      adv = 1;
      w = '0;
      a = regs[sa];
      b = op[3] ? {24'd0, sb} : regs[sb];
      if (!halt) begin
        case (op)
          rme_pkg::OP_HALT: begin
            halt = 1;
            adv = 0;
          end
          rme_pkg::OP_ADD, rme_pkg::OP_ADDI: begin
            w = a + b;
            wr = 1;
            z = (w == 0);
            n = w[31];
            c = (w < a) || (w < b);
            v = (a[31] ^ w[31]) & (b[31] ^ w[31]);
          end
          rme_pkg::OP_SUB, rme_pkg::OP_SUBI: begin
            w = a - b;
            wr = 1;
            z = (w == 0);
            n = w[31];
            c = $signed(a) > $signed(b);
            v = (a[31] ^ b[31]) & (a[31] ^ w[31]);
          end
          rme_pkg::OP_MUL, rme_pkg::OP_MULI: begin
            w = a * b;
            wr = 1;
          end
          rme_pkg::OP_DIV, rme_pkg::OP_DIVI: begin
            if (b != 0) begin
              ma = a[31] ? -a : a;
              mb = b[31] ? -b : b;
              q = ma / mb;
              w = (a[31] != b[31]) ? -q : q;
              wr = 1;
            end
          end
          rme_pkg::OP_LD, rme_pkg::OP_LDI: begin
            w = word_at(op == rme_pkg::OP_LD ? a : {24'd0, sb});
            wr = 1;
          end
          rme_pkg::OP_ST, rme_pkg::OP_STI: begin
            addr = (op == rme_pkg::OP_ST) ? regs[d] : {24'd0, d};
            if (addr <= 32'd4092) begin
              {dmem[addr + 3], dmem[addr + 2], dmem[addr + 1], dmem[addr]} = a;
              r.mem_written = 1;
              r.mem_address = addr[11:0];
              r.mem_value = a;
            end
          end
          rme_pkg::OP_MOV: begin
            w = a;
            wr = 1;
          end
          rme_pkg::OP_MOVI: begin
            w = {24'd0, sb};
            wr = 1;
          end
          default: begin
            if (op >= rme_pkg::OP_BR_FIRST && op <= rme_pkg::OP_BR_LAST &&
                cond_ok(op[3:0])) begin
              pc = pc + ({{24{sb[7]}}, sb} << 2);
              adv = 0;
            end
          end
        endcase
        if (wr) begin
          regs[d] = w;
          r.reg_written = 1;
          r.reg_index = d;
          r.reg_value = w;
        end
        if (adv) pc = pc + 4;
      end
      r.next_pc = pc;
      r.halted = halt;
      {r.fz, r.fn, r.fc, r.fv} = {z, n, c, v};
      pending.push_back(r);
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %h actual %h", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  int   cycles = 0;
  int   src_idle = 0;
  int   snk_idle = 0;
  int   sent = 0;
  exec_scoreboard sb = new();

  rme_in_if  in_ch();
  rme_out_if out_ch();

  register_machine_execute DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = 0;
    in_ch.dest_field = 0;
    in_ch.src_a_field = 0;
    in_ch.src_b_field = 0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_register_machine_execute: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.next_pc, out_ch.halted, out_ch.flag_z, out_ch.flag_n,
                         out_ch.flag_c, out_ch.flag_v, out_ch.reg_written, out_ch.reg_index,
                         out_ch.reg_value, out_ch.mem_written, out_ch.mem_address,
                         out_ch.mem_value});
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // valid stays high across back-to-back beats; it drops only on idle cycles
  task automatic send_instruction(logic [7:0] op, logic [7:0] d, logic [7:0] sa,
                                  logic [7:0] sbf);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.dest_field <= d;
    in_ch.src_a_field <= sa;
    in_ch.src_b_field <= sbf;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instruction(op, d, sa, sbf);
    sent++;
  endtask

  function automatic logic [7:0] rand_op();
    int k;
    k = $urandom_range(99);
    if (k < 3) return 8'($urandom_range(8'h1F, 8'hFF));
    if (k < 5) return 8'h08;
    if (k < 30) return 8'($urandom_range(rme_pkg::OP_BR_FIRST, rme_pkg::OP_BR_LAST));
    return 8'($urandom_range(1, 15));
  endfunction

  // random operands biased toward a few registers so values get reused
  function automatic logic [7:0] rand_reg();
    return ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15));
  endfunction

  task automatic run_random(int count);
    logic [7:0] op;
    repeat (count) begin
      op = rand_op();
      if (op == rme_pkg::OP_ST && $urandom_range(1))
        send_instruction(rme_pkg::OP_MOVI, 8'd3, 8'd0, 8'($urandom));
      send_instruction(op, (op == rme_pkg::OP_ST && $urandom_range(1)) ? 8'd3 : rand_reg(),
                       rand_reg(), ($urandom_range(3) == 0) ? 8'($urandom_range(8))
                                                             : 8'($urandom));
    end
  endtask

  initial begin
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, wrap cases, every operation but ADDI and HALT
    send_instruction(rme_pkg::OP_MOVI, 8'd1, 8'd0, 8'hFF);
    send_instruction(rme_pkg::OP_SUBI, 8'd2, 8'd0, 8'd1);
    send_instruction(rme_pkg::OP_MULI, 8'd3, 8'd2, 8'h80);
    send_instruction(rme_pkg::OP_ADD, 8'd4, 8'd3, 8'd3);
    send_instruction(rme_pkg::OP_SUB, 8'd5, 8'd3, 8'd2);
    send_instruction(rme_pkg::OP_DIV, 8'd6, 8'd5, 8'd2);
    send_instruction(rme_pkg::OP_DIVI, 8'd7, 8'd2, 8'd0);
    send_instruction(rme_pkg::OP_DIV, 8'd7, 8'd2, 8'd1);
    send_instruction(rme_pkg::OP_ADD, 8'd8, 8'd2, 8'd5);
    send_instruction(rme_pkg::OP_MUL, 8'd9, 8'd1, 8'd2);
    send_instruction(rme_pkg::OP_STI, 8'hFC, 8'd2, 8'd0);
    send_instruction(rme_pkg::OP_STI, 8'd5, 8'd5, 8'd0);
    send_instruction(rme_pkg::OP_LDI, 8'd10, 8'd0, 8'd6);
    send_instruction(rme_pkg::OP_LD, 8'd11, 8'd1, 8'd0);
    send_instruction(rme_pkg::OP_ST, 8'd2, 8'd1, 8'd0);
    send_instruction(rme_pkg::OP_LD, 8'd12, 8'd2, 8'd0);
    send_instruction(rme_pkg::OP_MOV, 8'd13, 8'd9, 8'd0);
    send_instruction(rme_pkg::OP_MOVI, 8'd14, 8'd0, 8'd3);
    send_instruction(8'h08, 8'd0, 8'd0, 8'd0);
    send_instruction(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_instruction(rme_pkg::OP_BR_LAST, 8'd0, 8'd0, 8'h80);
    send_instruction(rme_pkg::OP_BR_FIRST, 8'd0, 8'd0, 8'h7F);
    send_instruction(8'h11, 8'd0, 8'd0, 8'h01);
    src_idle = 27;
    snk_idle = 56;
    run_random(650);
    src_idle = 56;
    snk_idle = 27;
    run_random(650);
    src_idle = 0;
    snk_idle = 0;
    run_random(650);
    send_instruction(rme_pkg::OP_HALT, 8'd0, 8'd0, 8'd0);
    run_random(30);
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_register_machine_execute: PASS");
    else
      $display("tb_register_machine_execute: FAIL");
    $finish;
  end
endmodule
